FILE: src/bps_pkg.sv
// Shared types and constants of the bilinear pixel sampler.
package bps_pkg;

  localparam int COORD_W   = 16;  // query coordinate width
  localparam int CALC_W    = 26;  // byte address arithmetic width
  localparam int STRIDE_W  = 12;  // row stride in bytes
  localparam int DIM_W     = 9;   // width and height registers
  localparam int LAYER_W   = 3;   // layer count register
  localparam int CH_W      = 2;
  localparam int PIX_W     = 8;
  localparam int WADDR_W   = 18;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYERS = 2'd2;

  localparam logic [DIM_W-1:0]   WIDTH_RST  = 9'd256;
  localparam logic [DIM_W-1:0]   HEIGHT_RST = 9'd256;
  localparam logic [LAYER_W-1:0] LAYERS_RST = 3'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BASE,
    ST_ADDR,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_RD4,
    ST_MUL,
    ST_SUM,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    NBR_00,
    NBR_10,
    NBR_01,
    NBR_11
  } nbr_t;

  typedef struct packed {
    logic wr;       // store one image byte
    logic load;     // latch query coordinates
    logic base;     // row base, column offset, range check
    logic addr;     // first neighbour address, store bound check
    logic rd_en;
    nbr_t rd_nbr;
    logic cap_en;
    nbr_t cap_nbr;
    logic mul;      // first products
    logic sum;      // cross product and partial sum
    logic fin;      // final sum, clamp, present result
  } dp_cmd_t;

  typedef struct packed {
    logic err;
  } dp_sts_t;

endpackage

FILE: src/bps_ctrl.sv
// Sequencer of the bilinear pixel sampler: issues byte writes and steps one query through the datapath.
module bps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              operation,
  input  bps_pkg::dp_sts_t  sts,
  output logic              busy,
  output bps_pkg::dp_cmd_t  cmd
);
  import bps_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    busy        = 1'b1;
    cmd         = '0;
    cmd.rd_nbr  = NBR_00;
    cmd.cap_nbr = NBR_00;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (operation) begin
            cmd.load   = 1'b1;
            state_next = ST_BASE;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      ST_BASE: begin
        cmd.base   = 1'b1;
        state_next = ST_ADDR;
      end
      ST_ADDR: begin
        cmd.addr   = 1'b1;
        state_next = sts.err ? ST_FIN : ST_RD0;
      end
      // one read per cycle, data lands in the read register in the cycle after
      ST_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_nbr = NBR_00;
        state_next = ST_RD1;
      end
      ST_RD1: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_nbr  = NBR_10;
        cmd.cap_en  = 1'b1;
        cmd.cap_nbr = NBR_00;
        state_next  = ST_RD2;
      end
      ST_RD2: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_nbr  = NBR_01;
        cmd.cap_en  = 1'b1;
        cmd.cap_nbr = NBR_10;
        state_next  = ST_RD3;
      end
      ST_RD3: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_nbr  = NBR_11;
        cmd.cap_en  = 1'b1;
        cmd.cap_nbr = NBR_01;
        state_next  = ST_RD4;
      end
      ST_RD4: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_nbr = NBR_11;
        state_next  = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin    = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/bps_datapath.sv
// Datapath of the bilinear pixel sampler: config registers, image store, address and blend math.
module bps_datapath #(
  parameter int STORE_BYTES = 262144,
  parameter int FRAC_BITS   = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bps_pkg::dp_cmd_t                    cmd,
  output bps_pkg::dp_sts_t                    sts,
  input  logic                                cfg_write,
  input  logic [bps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bps_pkg::DIM_W-1:0]           cfg_data,
  input  logic [bps_pkg::WADDR_W-1:0]         write_address,
  input  logic [bps_pkg::PIX_W-1:0]           write_data,
  input  logic [bps_pkg::COORD_W-1:0]         x_pos,
  input  logic [bps_pkg::COORD_W-1:0]         y_pos,
  input  logic [bps_pkg::CH_W-1:0]            channel,
  output logic                                done,
  output logic [bps_pkg::PIX_W-1:0]           pixel_value,
  output logic                                status
);
  import bps_pkg::*;

  localparam int AW    = $clog2(STORE_BYTES);
  localparam int PW    = COORD_W - FRAC_BITS;      // integer part of a coordinate
  localparam int P1_W  = PIX_W + 1 + FRAC_BITS + 1;  // edge difference times fraction
  localparam int T_W   = PIX_W + 2 + FRAC_BITS + 1;  // cross term times fx
  localparam int T2_W  = T_W + FRAC_BITS + 1;        // cross term times fx*fy
  localparam int ACC_W = 2 * FRAC_BITS + 12;
  localparam logic [CALC_W-1:0] STORE_LIM = CALC_W'(STORE_BYTES);

  // configuration
  logic [DIM_W-1:0]    width_q, height_q;
  logic [LAYER_W-1:0]  layers_q;
  logic [STRIDE_W-1:0] stride_q;
  logic [STRIDE_W:0]   stride_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      layers_q <= LAYERS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_q  <= cfg_data;
        CFG_HEIGHT: height_q <= cfg_data;
        CFG_LAYERS: layers_q <= cfg_data[LAYER_W-1:0];
        default: ;
      endcase
    end
  end

  // row stride in bytes, rounded up to a multiple of 4
  assign stride_raw = (STRIDE_W+1)'(width_q * layers_q) + (STRIDE_W+1)'(3);

  always_ff @(posedge clk) begin
    stride_q <= {stride_raw[STRIDE_W-1:2], 2'b00};
  end

  // query latch
  logic [PW-1:0]        px_q, py_q;
  logic [FRAC_BITS-1:0] fx_q, fy_q;
  logic [CH_W-1:0]      ch_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_q <= x_pos[COORD_W-1:FRAC_BITS];
      py_q <= y_pos[COORD_W-1:FRAC_BITS];
      fx_q <= x_pos[FRAC_BITS-1:0];
      fy_q <= y_pos[FRAC_BITS-1:0];
      ch_q <= channel;
    end
  end

  // address generation
  logic [STRIDE_W+PW-1:0] row_prod;
  logic [LAYER_W+PW-1:0]  col_prod;
  logic [CALC_W-1:0]      row_base_q, col_off_q, a00_q, a00, a11;
  logic                   range_err_q, err_q, range_err, store_err;

  assign row_prod  = stride_q * py_q;
  assign col_prod  = layers_q * px_q;
  assign range_err = (CALC_W'(px_q) + CALC_W'(1) >= CALC_W'(width_q))
                   | (CALC_W'(py_q) + CALC_W'(1) >= CALC_W'(height_q))
                   | (LAYER_W'(ch_q) >= layers_q);

  always_ff @(posedge clk) begin
    if (cmd.base) begin
      row_base_q  <= CALC_W'(row_prod);
      col_off_q   <= CALC_W'(col_prod) + CALC_W'(ch_q);
      range_err_q <= range_err;
    end
  end

  assign a00       = row_base_q + col_off_q;
  assign a11       = a00 + CALC_W'(stride_q) + CALC_W'(layers_q);
  assign store_err = a11 >= STORE_LIM;
  assign sts.err   = range_err_q | store_err;

  always_ff @(posedge clk) begin
    if (cmd.addr) begin
      a00_q <= a00;
      err_q <= range_err_q | store_err;
    end
  end

  // image store, single port
  logic [PIX_W-1:0]  mem [STORE_BYTES];
  logic [PIX_W-1:0]  rdata_q;
  logic [CALC_W-1:0] rd_off, rd_addr, wr_addr;
  logic [AW-1:0]     port_idx;
  logic              mem_we;

  always_comb begin
    case (cmd.rd_nbr)
      NBR_00:  rd_off = '0;
      NBR_10:  rd_off = CALC_W'(layers_q);
      NBR_01:  rd_off = CALC_W'(stride_q);
      NBR_11:  rd_off = CALC_W'(stride_q) + CALC_W'(layers_q);
      default: rd_off = '0;
    endcase
  end

  assign rd_addr  = a00_q + rd_off;
  assign wr_addr  = CALC_W'(write_address);
  assign mem_we   = cmd.wr && (wr_addr < STORE_LIM);
  assign port_idx = cmd.wr ? wr_addr[AW-1:0] : rd_addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[port_idx] <= write_data;
    end
    if (cmd.rd_en) begin
      rdata_q <= mem[port_idx];
    end
  end

  logic [PIX_W-1:0] v00_q, v10_q, v01_q, v11_q;

  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      case (cmd.cap_nbr)
        NBR_00:  v00_q <= rdata_q;
        NBR_10:  v10_q <= rdata_q;
        NBR_01:  v01_q <= rdata_q;
        NBR_11:  v11_q <= rdata_q;
        default: v00_q <= rdata_q;
      endcase
    end
  end

  // blend: v00 << 2F + ((v01-v00)*fy + (v10-v00)*fx) << F + c3*fx*fy
  logic signed [PIX_W:0]     dy, dx;
  logic signed [PIX_W+1:0]   c3;
  logic signed [FRAC_BITS:0] fx_s, fy_s;
  logic signed [P1_W-1:0]    d1_q, d2_q;
  logic signed [P1_W:0]      d12;
  logic signed [T_W-1:0]     t_q;
  logic signed [T2_W-1:0]    t2_q;
  logic signed [ACC_W-1:0]   part_q, acc, d12_ext, v00_ext, t2_ext;

  assign dy   = $signed({1'b0, v01_q}) - $signed({1'b0, v00_q});
  assign dx   = $signed({1'b0, v10_q}) - $signed({1'b0, v00_q});
  assign c3   = $signed({2'b00, v00_q}) - $signed({2'b00, v10_q})
              - $signed({2'b00, v01_q}) + $signed({2'b00, v11_q});
  assign fx_s = $signed({1'b0, fx_q});
  assign fy_s = $signed({1'b0, fy_q});

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      d1_q <= dy * fy_s;
      d2_q <= dx * fx_s;
      t_q  <= c3 * fx_s;
    end
  end

  assign d12     = {d1_q[P1_W-1], d1_q} + {d2_q[P1_W-1], d2_q};
  assign d12_ext = {{(ACC_W-P1_W-1-FRAC_BITS){d12[P1_W]}}, d12, {FRAC_BITS{1'b0}}};
  assign v00_ext = $signed({{(ACC_W-PIX_W-2*FRAC_BITS){1'b0}}, v00_q, {(2*FRAC_BITS){1'b0}}});

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      t2_q   <= t_q * fy_s;
      part_q <= v00_ext + d12_ext;
    end
  end

  // the cross product already spans the full accumulator width
  assign t2_ext = t2_q;
  assign acc    = part_q + t2_ext;

  logic [PIX_W-1:0] clamped;

  always_comb begin
    if (acc[ACC_W-1]) begin
      clamped = '0;
    end else if (|acc[ACC_W-2:2*FRAC_BITS+PIX_W]) begin
      clamped = '1;
    end else begin
      clamped = acc[2*FRAC_BITS+PIX_W-1:2*FRAC_BITS];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      pixel_value <= err_q ? '0 : clamped;
      status      <= err_q;
    end
  end

endmodule

FILE: src/bilinear_pixel_sampler_core.sv
// Top level of the bilinear pixel sampler: sequencer plus datapath.
//
// Usage:
//  - Command channel: an item transfers at a rising edge with start high and
//    busy low. operation 0 writes write_data to byte write_address of the
//    image store (ignored at or beyond STORE_BYTES); it gives no result and
//    leaves busy low, so writes can stream back to back.
//  - operation 1 samples channel at (x_pos, y_pos), unsigned fixed point with
//    FRAC_BITS fraction bits. busy is high from the transfer through the final
//    state FIN, which comes early when the query is out of range; done strobes
//    for one cycle in the cycle after that, with pixel_value and status. busy
//    is already low in the done cycle, so the next item can transfer then.
//  - The sample time is set by the single-port image store (one neighbour
//    byte per cycle, four registered reads) plus the address setup and a
//    three-step multiply/accumulate.
//  - Config: cfg_write with cfg_index 0/1/2 writes width, height, layer count
//    in the same cycle; write only while no sample is in flight.
//  - Reset (rst, synchronous) returns to idle and restores 256 x 256 x 1;
//    store contents are undefined until written. The receiver cannot stall:
//    each result is shown for exactly one cycle.
module bilinear_pixel_sampler_core #(
  parameter int STORE_BYTES = 262144,
  parameter int FRAC_BITS   = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           operation,
  input  logic [bps_pkg::WADDR_W-1:0]    write_address,
  input  logic [bps_pkg::PIX_W-1:0]      write_data,
  input  logic [bps_pkg::COORD_W-1:0]    x_pos,
  input  logic [bps_pkg::COORD_W-1:0]    y_pos,
  input  logic [bps_pkg::CH_W-1:0]       channel,
  output logic                           done,
  output logic [bps_pkg::PIX_W-1:0]      pixel_value,
  output logic                           status,
  input  logic                           cfg_write,
  input  logic [bps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bps_pkg::DIM_W-1:0]      cfg_data
);
  import bps_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .sts       (sts),
    .busy      (busy),
    .cmd       (cmd)
  );

  bps_datapath #(
    .STORE_BYTES (STORE_BYTES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .write_address (write_address),
    .write_data    (write_data),
    .x_pos         (x_pos),
    .y_pos         (y_pos),
    .channel       (channel),
    .done          (done),
    .pixel_value   (pixel_value),
    .status        (status)
  );

endmodule

FILE: src/bps_checker.sv
// Port-level checks of the bilinear pixel sampler, bound to the top level.
module bps_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      operation,
  input logic                      done,
  input logic [bps_pkg::PIX_W-1:0] pixel_value,
  input logic                      status
);

  // a result always comes after the sequencer has let go
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // a sample transfer occupies the block
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation) |=> busy)
    else $error("sample did not raise busy");

  // a byte write leaves busy low and yields nothing
  a_write_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !operation) |=> (!busy && !done))
    else $error("write stalled or produced a result");

  // error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (pixel_value == '0))
    else $error("error result with nonzero value");

  // each result strobes for one cycle only
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

endmodule

bind bilinear_pixel_sampler_core bps_checker u_bps_checker (.*);

FILE: tb/sv/pixel_check_pkg.sv
`timescale 1ns / 100ps
// Command type and result scoreboard for the bilinear pixel sampler bench.
package pixel_check_pkg;
  import bps_pkg::*;

  localparam int STORE_BYTES = 262144;
  localparam int FRAC_BITS   = 8;

  // index 3 is not decoded by the block
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef struct {
    op_t                op;
    logic [WADDR_W-1:0] waddr;
    logic [PIX_W-1:0]   wdata;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CH_W-1:0]    ch;
  } sampler_cmd_t;

  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic             err;
  } pixel_result_t;

  class pixel_scoreboard;
    logic [PIX_W-1:0]   image_mem [STORE_BYTES];
    bit                 filled [STORE_BYTES];
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [LAYER_W-1:0] layers_reg;
    pixel_result_t      expected_pixels [$];
    int                 failures;
    int                 writes_seen;
    int                 samples_seen;
    int                 flagged_seen;

    function new();
      width_reg    = WIDTH_RST;
      height_reg   = HEIGHT_RST;
      layers_reg   = LAYERS_RST;
      failures     = 0;
      writes_seen  = 0;
      samples_seen = 0;
      flagged_seen = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      case (idx)
        CFG_WIDTH:  width_reg  = data;
        CFG_HEIGHT: height_reg = data;
        CFG_LAYERS: layers_reg = data[LAYER_W-1:0];
        default: ;
      endcase
    endfunction

    // Neighbour byte addresses; returns 1 only when the sample reads the store.
    function bit locate(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                        logic [CH_W-1:0] ch, output longint addr [4]);
      longint px, py, lc, stride;
      px = x >> FRAC_BITS;
      py = y >> FRAC_BITS;
      lc = layers_reg;
      for (int i = 0; i < 4; i++) addr[i] = 0;
      if (px + 1 >= width_reg || py + 1 >= height_reg || ch >= layers_reg) return 0;
      stride = (longint'(width_reg) * lc + 3) & ~longint'(3);
      addr[NBR_00] = stride * py + lc * px + ch;
      addr[NBR_10] = addr[NBR_00] + lc;
      addr[NBR_01] = addr[NBR_00] + stride;
      addr[NBR_11] = addr[NBR_01] + lc;
      return addr[NBR_11] < STORE_BYTES;
    endfunction

    function pixel_result_t interpolate(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                        logic [CH_W-1:0] ch);
      longint        addr [4];
      longint        v [4];
      longint        fx, fy, one, acc, whole;
      pixel_result_t r;
      r.pixel = '0;
      r.err   = 1'b1;
      if (!locate(x, y, ch, addr)) return r;
      for (int i = 0; i < 4; i++) v[i] = image_mem[addr[i]];
      one = longint'(1) << FRAC_BITS;
      fx  = x & (one - 1);
      fy  = y & (one - 1);
      acc = v[NBR_00] * one * one
          + (v[NBR_01] - v[NBR_00]) * fy * one
          + (v[NBR_10] - v[NBR_00]) * fx * one
          + (v[NBR_00] - v[NBR_10] - v[NBR_01] + v[NBR_11]) * fx * fy;
      whole = (acc < 0) ? 0 : (acc >> (2 * FRAC_BITS));
      if (whole > 255) whole = 255;
      r.pixel = whole[PIX_W-1:0];
      r.err   = 1'b0;
      return r;
    endfunction

    function void note_transfer(sampler_cmd_t cmd);
      pixel_result_t r;
      if (cmd.op == OP_WRITE) begin
        writes_seen++;
        if (cmd.waddr < STORE_BYTES) begin
          image_mem[cmd.waddr] = cmd.wdata;
          filled[cmd.waddr]    = 1'b1;
        end
      end else begin
        samples_seen++;
        r = interpolate(cmd.x, cmd.y, cmd.ch);
        if (r.err) flagged_seen++;
        expected_pixels.push_back(r);
      end
    endfunction

    function void check_result(logic [PIX_W-1:0] pixel, logic err);
      pixel_result_t e;
      if (expected_pixels.size() == 0) begin
        failures++;
        $display("%0t: unexpected result: expected none, actual pixel %0d status %0b",
                 $time, pixel, err);
        return;
      end
      e = expected_pixels.pop_front();
      if (pixel !== e.pixel) begin
        failures++;
        $display("%0t: pixel_value mismatch: expected %0d, actual %0d",
                 $time, e.pixel, pixel);
      end
      if (err !== e.err) begin
        failures++;
        $display("%0t: status mismatch: expected %0b, actual %0b", $time, e.err, err);
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

endpackage

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// Top-level testbench of the bilinear pixel sampler core.
module tb;
  import bps_pkg::*;
  import pixel_check_pkg::*;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 start         = 1'b0;
  logic                 busy;
  logic                 operation     = 1'b0;
  logic [WADDR_W-1:0]   write_address = '0;
  logic [PIX_W-1:0]     write_data    = '0;
  logic [COORD_W-1:0]   x_pos         = '0;
  logic [COORD_W-1:0]   y_pos         = '0;
  logic [CH_W-1:0]      channel       = '0;
  logic                 done;
  logic [PIX_W-1:0]     pixel_value;
  logic                 status;
  logic                 cfg_write     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [DIM_W-1:0]     cfg_data      = '0;

  pixel_scoreboard sb;
  int              burst_left     = 0;
  bit              steady         = 1'b0;
  int              settings_used  = 0;

  bilinear_pixel_sampler_core #(
    .STORE_BYTES(STORE_BYTES),
    .FRAC_BITS  (FRAC_BITS)
  ) uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(pixel_value, status);
  end

  // Sender gaps: bursts of random length, junk on the fields while start is low.
  task automatic pace();
    int gap;
    burst_left--;
    if (steady || burst_left > 0) return;
    burst_left = $urandom_range(1, 16);
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
    if (gap == 0) return;
    start <= 1'b0;
    repeat (gap) begin
      operation     <= 1'($urandom);
      write_address <= WADDR_W'($urandom);
      write_data    <= PIX_W'($urandom);
      x_pos         <= COORD_W'($urandom);
      y_pos         <= COORD_W'($urandom);
      channel       <= CH_W'($urandom);
      @(posedge clk);
    end
  endtask

  task automatic issue(sampler_cmd_t cmd);
    start         <= 1'b1;
    operation     <= cmd.op;
    write_address <= cmd.waddr;
    write_data    <= cmd.wdata;
    x_pos         <= cmd.x;
    y_pos         <= cmd.y;
    channel       <= cmd.ch;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_transfer(cmd);
    pace();
  endtask

  function automatic logic [PIX_W-1:0] rand_byte();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic int rand_frac();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return (1 << FRAC_BITS) - 1;
      default: return $urandom_range(0, (1 << FRAC_BITS) - 1);
    endcase
  endfunction

  task automatic store_byte(logic [WADDR_W-1:0] a, logic [PIX_W-1:0] d);
    sampler_cmd_t c;
    c.op    = OP_WRITE;
    c.waddr = a;
    c.wdata = d;
    c.x     = COORD_W'($urandom);
    c.y     = COORD_W'($urandom);
    c.ch    = CH_W'($urandom);
    issue(c);
  endtask

  // Neighbours that were never written (and some others) get fresh bytes first.
  task automatic sample_at(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [CH_W-1:0] ch);
    sampler_cmd_t c;
    longint       addr [4];
    if (sb.locate(x, y, ch, addr)) begin
      foreach (addr[i]) begin
        if (!sb.filled[addr[i]] || $urandom_range(0, 2) == 0)
          store_byte(WADDR_W'(addr[i]), rand_byte());
      end
    end
    c.op    = OP_SAMPLE;
    c.waddr = WADDR_W'($urandom);
    c.wdata = PIX_W'($urandom);
    c.x     = x;
    c.y     = y;
    c.ch    = ch;
    issue(c);
  endtask

  task automatic random_sample();
    int w, h, lc, xmax, ymax, px, py;
    w  = sb.width_reg;
    h  = sb.height_reg;
    lc = (sb.layers_reg > 4) ? 4 : sb.layers_reg;
    if ($urandom_range(0, 4) != 0 && w >= 2 && h >= 2 && lc != 0) begin
      xmax = (w - 2 > 255) ? 255 : w - 2;
      ymax = (h - 2 > 255) ? 255 : h - 2;
      px   = ($urandom_range(0, 3) == 0) ? xmax : $urandom_range(0, xmax);
      py   = ($urandom_range(0, 3) == 0) ? ymax : $urandom_range(0, ymax);
      sample_at(COORD_W'((px << FRAC_BITS) | rand_frac()),
                COORD_W'((py << FRAC_BITS) | rand_frac()),
                CH_W'($urandom_range(0, lc - 1)));
    end else begin
      sample_at(COORD_W'($urandom), COORD_W'($urandom), CH_W'($urandom));
    end
  endtask

  // Drain outstanding samples before touching the registers.
  task automatic settle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic program_regs(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                              logic [LAYER_W-1:0] l);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [DIM_W-1:0]     data [4];
    settle();
    idx     = '{CFG_WIDTH, CFG_HEIGHT, CFG_LAYERS, CFG_SPARE};
    data[0] = w;
    data[1] = h;
    data[2] = DIM_W'($urandom);
    data[2][LAYER_W-1:0] = l;   // upper bits are don't-care
    data[3] = DIM_W'($urandom);
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= data[i];
      @(posedge clk);
      sb.set_register(idx[i], data[i]);
    end
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                           logic [LAYER_W-1:0] l, int n, bit quiet);
    program_regs(w, h, l);
    steady = quiet;
    repeat (n) begin
      if ($urandom_range(0, 99) < 70) random_sample();
      else store_byte(WADDR_W'($urandom), rand_byte());
    end
    steady = 1'b0;
  endtask

  function automatic logic [DIM_W-1:0] rand_dim();
    return DIM_W'(($urandom_range(0, 4) != 0) ? $urandom_range(1, 256)
                                               : $urandom_range(0, 511));
  endfunction

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset geometry 256 x 256 x 1, corner cell with opposite extremes
    store_byte(18'd0, 8'd255);
    store_byte(18'd1, 8'd0);
    store_byte(18'd256, 8'd0);
    store_byte(18'd257, 8'd255);
    sample_at(16'h0000, 16'h0000, 2'd0);
    sample_at(16'h00FF, 16'h00FF, 2'd0);
    sample_at(16'h0080, 16'h0040, 2'd0);
    sample_at(16'hFEFF, 16'hFEFF, 2'd0);   // last full cell
    sample_at(16'hFF00, 16'h0000, 2'd0);   // right neighbour off the image
    sample_at(16'h0000, 16'hFF00, 2'd0);   // lower neighbour off the image
    sample_at(16'h0000, 16'h0000, 2'd1);   // channel not below layer count
    sample_at(16'hFFFF, 16'hFFFF, 2'd3);
    store_byte(18'h3FFFF, 8'hA5);

    program_regs(9'd0, 9'd256, 3'd1);      // zero width
    sample_at(16'h0000, 16'h0000, 2'd0);
    program_regs(9'd2, 9'd2, 3'd0);        // zero layers
    sample_at(16'h0000, 16'h0000, 2'd0);
    program_regs(9'd511, 9'd511, 3'd7);    // oversized registers
    sample_at(16'hFEFF, 16'hFEFF, 2'd3);   // neighbours past the end of the store
    sample_at(16'h0180, 16'h0240, 2'd3);
    program_regs(9'd2, 9'd2, 3'd4);
    sample_at(16'h00FF, 16'h00FF, 2'd3);
    program_regs(9'd1, 9'd1, 3'd1);
    sample_at(16'h0000, 16'h0000, 2'd0);

    run_phase(9'd256, 9'd256, 3'd1, 20, 1'b0);
    run_phase(9'd256, 9'd256, 3'd4, 15, 1'b0);
    run_phase(9'd2, 9'd2, 3'd1, 15, 1'b1);
    repeat (5) begin
      run_phase(rand_dim(), rand_dim(),
                LAYER_W'(($urandom_range(0, 6) != 0) ? $urandom_range(1, 4)
                                                      : $urandom_range(0, 7)),
                12, 1'b0);
    end

    settle();
    repeat (20) @(posedge clk);
    $display("Covered %0d byte writes and %0d samples (%0d flagged out of range)",
             sb.writes_seen, sb.samples_seen, sb.flagged_seen);
    $display("across %0d register settings with bursty start timing.", settings_used);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: run timed out", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
